[rtl/core/dnsrp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS response parser package
// Shared types, constants and helpers of the DNS response parser.
// ----------------------------------------------------------------------------
package dnsrp_pkg;

   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   localparam int ByteW  = 8;
   localparam int HalfW  = 16;
   localparam int WordW  = 32;

   localparam logic [ByteW-1:0] HeaderLastOffset = 8'd11;
   localparam logic [ByteW-1:0] QtcLastOffset    = 8'd3;
   localparam logic [ByteW-1:0] RecordLastOffset = 8'd11;
   localparam logic [ByteW-1:0] AddrLastOffset   = 8'd3;
   localparam logic [HalfW-1:0] TypeA            = 16'd1;
   localparam logic [HalfW-1:0] ClassIn          = 16'd1;
   localparam logic [HalfW-1:0] Ipv4RdLength     = 16'd4;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_IPV4   = 2'd1,
      KIND_END    = 2'd2
   } result_kind_type;

   typedef enum logic [7:0] {
      PH_IDLE   = 8'b0000_0001,
      PH_HEADER = 8'b0000_0010,
      PH_QNAME  = 8'b0000_0100,
      PH_QTC    = 8'b0000_1000,
      PH_RECORD = 8'b0001_0000,
      PH_ADDR   = 8'b0010_0000,
      PH_SKIP   = 8'b0100_0000,
      PH_DONE   = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      result_kind_type  kind;
      logic [HalfW-1:0] query_class;
      logic [HalfW-1:0] query_type;
      logic [HalfW-1:0] additional_count;
      logic [HalfW-1:0] authority_count;
      logic [HalfW-1:0] answer_count;
      logic [HalfW-1:0] question_count;
      logic [HalfW-1:0] header_flags;
      logic [HalfW-1:0] message_id;
      logic [HalfW-1:0] record_number;
      logic [WordW-1:0] time_to_live;
      logic [WordW-1:0] ipv4_address;
   } rsp_item_type;

   typedef struct packed {
      logic         v0;
      logic         v1;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

   function automatic logic [HalfW-1:0] shift16(input logic [HalfW-1:0] r,
                                                input logic [ByteW-1:0] b);
      return {r[ByteW-1:0], b};
   endfunction

   function automatic rsp_item_type make_end(input logic [HalfW-1:0] found);
      rsp_item_type it;
      it               = '0;
      it.kind          = KIND_END;
      it.record_number = found;
      return it;
   endfunction

   function automatic rsp_item_type make_ipv4(input logic [WordW-1:0] addr,
                                              input logic [WordW-1:0] ttl,
                                              input logic [HalfW-1:0] num);
      rsp_item_type it;
      it               = '0;
      it.kind          = KIND_IPV4;
      it.ipv4_address  = addr;
      it.time_to_live  = ttl;
      it.record_number = num;
      return it;
   endfunction

endpackage

[rtl/core/dnsrp_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS response parser core
// Byte-wide parse state machine that turns each accepted request into zero,
// one or two result items.
// ----------------------------------------------------------------------------
module dnsrp_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               req_byte,
   input  logic                     req_start,
   input  logic                     csr_we,
   input  logic [7:0]               csr_wdata,
   output dnsrp_pkg::push_type      push
);
   import dnsrp_pkg::*;

   phase_type        phase_ff, phase_in, ph;
   logic [ByteW-1:0] off_ff, off_in, o, sub;
   logic [ByteW-1:0] qlen_ff, qlen_in;
   logic [HalfW-1:0] ans_ff, ans_in;
   logic [HalfW-1:0] found_ff, found_in;
   logic [HalfW-1:0] id_ff, id_in;
   logic [HalfW-1:0] flags_ff, flags_in;
   logic [HalfW-1:0] counts_ff [4];
   logic [HalfW-1:0] counts_in [4];
   logic [HalfW-1:0] qtc_ff [2];
   logic [HalfW-1:0] qtc_in [2];
   logic [HalfW-1:0] rtc_ff [2];
   logic [HalfW-1:0] rtc_in [2];
   logic [WordW-1:0] ttl_ff, ttl_in;
   logic [HalfW-1:0] rdlen_ff, rdlen_in;
   logic [WordW-1:0] addr_ff, addr_in;
   rsp_item_type     hdr_item;

   always_comb begin
      hdr_item                  = '0;
      hdr_item.kind             = KIND_HEADER;
      hdr_item.message_id       = id_ff;
      hdr_item.header_flags     = flags_ff;
      hdr_item.question_count   = counts_ff[0];
      hdr_item.answer_count     = counts_ff[1];
      hdr_item.authority_count  = counts_ff[2];
      hdr_item.additional_count = counts_ff[3];
   end

   always_comb begin
      phase_in  = phase_ff;
      off_in    = off_ff;
      ans_in    = ans_ff;
      found_in  = found_ff;
      id_in     = id_ff;
      flags_in  = flags_ff;
      counts_in = counts_ff;
      qtc_in    = qtc_ff;
      rtc_in    = rtc_ff;
      ttl_in    = ttl_ff;
      rdlen_in  = rdlen_ff;
      addr_in   = addr_ff;
      qlen_in   = csr_we ? csr_wdata : qlen_ff;
      ph        = phase_ff;
      o         = off_ff;
      sub       = off_ff - 8'd4;
      push      = '0;
      if (accept) begin
         ph       = req_start ? PH_HEADER : phase_ff;
         o        = req_start ? '0 : off_ff;
         found_in = req_start ? '0 : found_ff;
         sub      = o - 8'd4;
         phase_in = ph;
         off_in   = o;
         unique case (ph)
            PH_HEADER: begin
               if (o < 8'd2) begin
                  id_in = shift16(id_ff, req_byte);
               end else if (o < 8'd4) begin
                  flags_in = shift16(flags_ff, req_byte);
               end else begin
                  for (int i = 0; i < 4; i++) begin
                     if (sub[2:1] == 2'(i)) begin
                        counts_in[i] = shift16(counts_ff[i], req_byte);
                     end
                  end
               end
               if (o >= HeaderLastOffset) begin
                  if (qlen_ff != '0) begin
                     phase_in = PH_QNAME;
                     off_in   = qlen_ff;
                  end else begin
                     phase_in = PH_QTC;
                     off_in   = '0;
                  end
               end else begin
                  off_in = o + 8'd1;
               end
            end
            PH_QNAME: begin
               off_in = o - 8'd1;
               if (off_in == '0) begin
                  phase_in = PH_QTC;
               end
            end
            PH_QTC: begin
               if (o[1]) begin
                  qtc_in[1] = shift16(qtc_ff[1], req_byte);
               end else begin
                  qtc_in[0] = shift16(qtc_ff[0], req_byte);
               end
               if (o >= QtcLastOffset) begin
                  push.v0                = 1'b1;
                  push.item0             = hdr_item;
                  push.item0.query_type  = qtc_in[0];
                  push.item0.query_class = qtc_in[1];
                  off_in                 = '0;
                  if (flags_ff[3:0] != 4'd0 || counts_ff[1] == '0) begin
                     push.v1    = 1'b1;
                     push.item1 = make_end(found_in);
                     phase_in   = PH_DONE;
                  end else begin
                     ans_in   = counts_ff[1];
                     phase_in = PH_RECORD;
                  end
               end else begin
                  off_in = o + 8'd1;
               end
            end
            PH_RECORD: begin
               if (o >= 8'd2 && o < 8'd6) begin
                  if (o < 8'd4) begin
                     rtc_in[0] = shift16(rtc_ff[0], req_byte);
                  end else begin
                     rtc_in[1] = shift16(rtc_ff[1], req_byte);
                  end
               end else if (o >= 8'd6 && o < 8'd10) begin
                  ttl_in = {ttl_ff[WordW-ByteW-1:0], req_byte};
               end else if (o >= 8'd10) begin
                  rdlen_in = shift16(rdlen_ff, req_byte);
               end
               if (o >= RecordLastOffset) begin
                  off_in = '0;
                  if (rtc_in[0] == TypeA && rtc_in[1] == ClassIn
                      && rdlen_in == Ipv4RdLength) begin
                     phase_in = PH_ADDR;
                  end else if (rdlen_in == '0) begin
                     ans_in = ans_ff - 16'd1;
                     if (ans_in == '0) begin
                        push.v0    = 1'b1;
                        push.item0 = make_end(found_in);
                        phase_in   = PH_DONE;
                     end else begin
                        phase_in = PH_RECORD;
                     end
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end else begin
                  off_in = o + 8'd1;
               end
            end
            PH_ADDR: begin
               addr_in = {addr_ff[WordW-ByteW-1:0], req_byte};
               if (o >= AddrLastOffset) begin
                  push.v0    = 1'b1;
                  push.item0 = make_ipv4(addr_in, ttl_ff, found_in);
                  found_in   = found_in + 16'd1;
                  ans_in     = ans_ff - 16'd1;
                  off_in     = '0;
                  if (ans_in == '0) begin
                     push.v1    = 1'b1;
                     push.item1 = make_end(found_in);
                     phase_in   = PH_DONE;
                  end else begin
                     phase_in = PH_RECORD;
                  end
               end else begin
                  off_in = o + 8'd1;
               end
            end
            PH_SKIP: begin
               rdlen_in = rdlen_ff - 16'd1;
               if (rdlen_in == '0) begin
                  ans_in = ans_ff - 16'd1;
                  off_in = '0;
                  if (ans_in == '0) begin
                     push.v0    = 1'b1;
                     push.item0 = make_end(found_in);
                     phase_in   = PH_DONE;
                  end else begin
                     phase_in = PH_RECORD;
                  end
               end
            end
            default: begin
               phase_in = ph;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         off_ff   <= '0;
         qlen_ff  <= '0;
         ans_ff   <= '0;
         found_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         off_ff   <= off_in;
         qlen_ff  <= qlen_in;
         ans_ff   <= ans_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff     <= id_in;
      flags_ff  <= flags_in;
      counts_ff <= counts_in;
      qtc_ff    <= qtc_in;
      rtc_ff    <= rtc_in;
      ttl_ff    <= ttl_in;
      rdlen_ff  <= rdlen_in;
      addr_ff   <= addr_in;
   end

   a_second_needs_first: assert property (@(posedge clock) disable iff (reset)
      push.v1 |-> push.v0)
      else $error("second result pushed without a first");

   a_second_is_end: assert property (@(posedge clock) disable iff (reset)
      push.v1 |-> push.item1.kind == KIND_END)
      else $error("second result of a request is not an end result");

   a_quiet_when_done: assert property (@(posedge clock) disable iff (reset)
      (!req_start && (phase_ff == PH_DONE || phase_ff == PH_IDLE)) |-> !push.v0)
      else $error("result produced outside a message");

endmodule

[rtl/core/dnsrp_outq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS response parser result queue
// Small register queue that takes up to two results a cycle and hands one
// result per cycle to the result channel while rsp_ready is high.
// ----------------------------------------------------------------------------
module dnsrp_outq (
   input  logic                     clock,
   input  logic                     reset,
   input  dnsrp_pkg::push_type      push,
   output logic                     space_ok,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output dnsrp_pkg::rsp_item_type  rsp_item
);
   import dnsrp_pkg::*;

   rsp_item_type     mem_ff [QDepth];
   logic [QPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0] count_ff, count_in;
   logic [QPtrW-1:0] wr_next;
   logic             pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = mem_ff[rd_ptr_ff];
   assign space_ok  = (count_ff <= QCntW'(QDepth - 2));
   assign wr_next   = wr_ptr_ff + QPtrW'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPtrW'(push.v0) + QPtrW'(push.v1);
      rd_ptr_in = rd_ptr_ff + QPtrW'(pop);
      count_in  = count_ff + QCntW'(push.v0) + QCntW'(push.v1) - QCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.v0) begin
         mem_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.v1) begin
         mem_ff[wr_next] <= push.item1;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCntW'(QDepth))
      else $error("result queue count beyond its depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, count_ff} + (QCntW+1)'(push.v0) + (QCntW+1)'(push.v1))
         <= (QCntW+1)'(QDepth))
      else $error("result queue overflow");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && !push.v0) |=> count_ff == $past(count_ff) - QCntW'(1))
      else $error("result queue count wrong after a pop");

endmodule

[rtl/core/dns_response_parser_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS response parser, top level
// Parses a DNS response byte stream and reports the header, every IPv4
// A record and an end summary.
//
//  Channel  Direction  Payload
//  req_     in         tdata: data_byte; tuser: message_start
//  rsp_     out        tdata: address, TTL, record number, header fields
//                      tuser: result_kind
//  csr_     in         question_name_length, write only
//
// One request is taken per cycle while req_tready is high; the parse state
// updates in that cycle. A request gives zero, one or two results, held in
// a four-entry queue. req_tready falls while fewer than two queue entries
// are free. Synchronous active-high reset returns the parser to idle and
// empties the queue.
// ----------------------------------------------------------------------------
module dns_response_parser_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // [7:0] data_byte
   input  logic          req_tuser,   // [0] message_start
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [31:0] ipv4_address, [63:32] time_to_live, [79:64] record_number,
   // [95:80] message_id, [111:96] header_flags, [127:112] question_count,
   // [143:128] answer_count, [159:144] authority_count,
   // [175:160] additional_count, [191:176] query_type, [207:192] query_class
   output logic [207:0]  rsp_tdata,
   output logic [1:0]    rsp_tuser,   // [1:0] result_kind
   input  logic          csr_we,
   input  logic [7:0]    csr_wdata
);
   import dnsrp_pkg::*;

   push_type     push;
   rsp_item_type item;
   logic         space_ok;
   logic         accept;

   assign req_tready = space_ok;
   assign accept     = req_tvalid && req_tready;

   dnsrp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_byte  (req_tdata),
      .req_start (req_tuser),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .push      (push)
   );

   dnsrp_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (item)
   );

   assign rsp_tuser = item.kind;
   assign rsp_tdata = {item.query_class, item.query_type, item.additional_count,
                       item.authority_count, item.answer_count,
                       item.question_count, item.header_flags, item.message_id,
                       item.record_number, item.time_to_live, item.ipv4_address};

endmodule

[tb/sv/dns_response_parser_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS response parser testbench
// Feeds DNS response byte streams into the parser and predicts every header,
// IPv4 and end result in step with each accepted request. Directed messages
// cover error and empty answers, each kind of record, restarts and question
// name lengths. Random messages follow, some of them cut short or padded
// with stray bytes. Both channels idle and stall at random throughout.
// ----------------------------------------------------------------------------
module dns_response_parser_top_tb;
   import dnsrp_pkg::*;

   localparam int MaxGap       = 19;
   localparam int SettleCycles = 8;
   localparam int RandomBytes  = 100;
   localparam int ReportLimit  = 10;

   localparam logic [15:0] RrTypeA      = 16'd1;
   localparam logic [15:0] RrTypeCname  = 16'd5;
   localparam logic [15:0] RrTypeTxt    = 16'd16;
   localparam logic [15:0] RrTypeAaaa   = 16'd28;
   localparam logic [15:0] RrClassIn    = 16'd1;
   localparam logic [15:0] RrClassChaos = 16'd3;
   localparam logic [15:0] Ipv4Length   = 16'd4;
   localparam logic [15:0] FlagsAnswer  = 16'h8180;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = '0;
   logic         req_tuser  = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [207:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_we     = 1'b0;
   logic [7:0]   csr_wdata  = '0;

   // Parser state as predicted from the accepted requests.
   logic [7:0]   question_length = '0;
   phase_type    ps_phase        = PH_IDLE;
   logic [15:0]  ps_offset       = '0;
   logic [15:0]  ps_id           = '0;
   logic [15:0]  ps_flags        = '0;
   logic [15:0]  ps_counts [4]   = '{default: '0};
   logic [15:0]  ps_qtc [2]      = '{default: '0};
   logic [15:0]  ps_answers_left = '0;
   logic [15:0]  ps_rtc [2]      = '{default: '0};
   logic [31:0]  ps_ttl          = '0;
   logic [15:0]  ps_rdlen        = '0;
   logic [31:0]  ps_addr         = '0;
   logic [15:0]  ps_found        = '0;

   rsp_item_type parsed_results [$];
   logic [7:0]   frame_bytes [$];
   int           frame_bytes_sent = 0;
   int           failures         = 0;
   bit           req_burst        = 1'b0;
   bit           rsp_burst        = 1'b0;

   dns_response_parser_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= ReportLimit) $display("[%0t] mismatch: %s", $time, msg);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) note_failure($sformatf("%s expected %0h, got %0h", name, want, got));
   endfunction

   function automatic void emit_end();
      rsp_item_type r;
      r = '0;
      r.kind = KIND_END;
      r.record_number = ps_found;
      parsed_results.push_back(r);
      ps_phase = PH_DONE;
   endfunction

   function automatic void close_record();
      ps_answers_left = ps_answers_left - 16'd1;
      ps_offset = '0;
      if (ps_answers_left == 16'd0) emit_end();
      else ps_phase = PH_RECORD;
   endfunction

   function automatic void parse_byte(input logic [7:0] b, input logic first);
      rsp_item_type r;
      logic [15:0]  o;
      logic [15:0]  idx;
      if (first) begin
         ps_phase = PH_HEADER;
         ps_offset = '0;
         ps_found = '0;
      end
      o = ps_offset;
      case (ps_phase)
         PH_HEADER: begin
            if (o < 2) ps_id = {ps_id[7:0], b};
            else if (o < 4) ps_flags = {ps_flags[7:0], b};
            else begin
               idx = (o - 16'd4) >> 1;
               ps_counts[idx[1:0]] = {ps_counts[idx[1:0]][7:0], b};
            end
            if (o >= 11) begin
               if (question_length != 0) begin
                  ps_phase = PH_QNAME;
                  ps_offset = {8'd0, question_length};
               end else begin
                  ps_phase = PH_QTC;
                  ps_offset = '0;
               end
            end else begin
               ps_offset = o + 16'd1;
            end
         end
         PH_QNAME: begin
            ps_offset = ps_offset - 16'd1;
            if (ps_offset == 0) ps_phase = PH_QTC;
         end
         PH_QTC: begin
            ps_qtc[o[1]] = {ps_qtc[o[1]][7:0], b};
            if (o >= 3) begin
               r = '0;
               r.kind = KIND_HEADER;
               r.message_id = ps_id;
               r.header_flags = ps_flags;
               r.question_count = ps_counts[0];
               r.answer_count = ps_counts[1];
               r.authority_count = ps_counts[2];
               r.additional_count = ps_counts[3];
               r.query_type = ps_qtc[0];
               r.query_class = ps_qtc[1];
               parsed_results.push_back(r);
               ps_offset = '0;
               if (ps_flags[3:0] != 0 || ps_counts[1] == 0) begin
                  emit_end();
               end else begin
                  ps_answers_left = ps_counts[1];
                  ps_phase = PH_RECORD;
               end
            end else begin
               ps_offset = o + 16'd1;
            end
         end
         PH_RECORD: begin
            if (o >= 2 && o < 6) begin
               idx = o - 16'd2;
               ps_rtc[idx[1]] = {ps_rtc[idx[1]][7:0], b};
            end else if (o >= 6 && o < 10) begin
               ps_ttl = {ps_ttl[23:0], b};
            end else if (o >= 10) begin
               ps_rdlen = {ps_rdlen[7:0], b};
            end
            if (o >= 11) begin
               ps_offset = '0;
               if (ps_rtc[0] == RrTypeA && ps_rtc[1] == RrClassIn && ps_rdlen == Ipv4Length)
                  ps_phase = PH_ADDR;
               else if (ps_rdlen == 0) close_record();
               else ps_phase = PH_SKIP;
            end else begin
               ps_offset = o + 16'd1;
            end
         end
         PH_ADDR: begin
            ps_addr = {ps_addr[23:0], b};
            if (o >= 3) begin
               r = '0;
               r.kind = KIND_IPV4;
               r.ipv4_address = ps_addr;
               r.time_to_live = ps_ttl;
               r.record_number = ps_found;
               parsed_results.push_back(r);
               ps_found = ps_found + 16'd1;
               close_record();
            end else begin
               ps_offset = o + 16'd1;
            end
         end
         PH_SKIP: begin
            ps_rdlen = ps_rdlen - 16'd1;
            if (ps_rdlen == 0) close_record();
         end
         default: ;
      endcase
   endfunction

   function automatic void put_half(input logic [15:0] v);
      frame_bytes.push_back(v[15:8]);
      frame_bytes.push_back(v[7:0]);
   endfunction

   function automatic void put_header(input logic [15:0] id, input logic [15:0] flags,
                                      input logic [15:0] qd, input logic [15:0] an,
                                      input logic [15:0] ns, input logic [15:0] ar,
                                      input logic [15:0] qtype, input logic [15:0] qclass,
                                      input logic [7:0] qlen);
      put_half(id);
      put_half(flags);
      put_half(qd);
      put_half(an);
      put_half(ns);
      put_half(ar);
      repeat (qlen) frame_bytes.push_back(8'($urandom));
      put_half(qtype);
      put_half(qclass);
   endfunction

   function automatic void put_record(input logic [15:0] rtype, input logic [15:0] rclass,
                                      input logic [15:0] rdlen, input logic [31:0] ttl,
                                      input logic [31:0] addr);
      put_half({2'b11, 14'($urandom)});
      put_half(rtype);
      put_half(rclass);
      put_half(ttl[31:16]);
      put_half(ttl[15:0]);
      put_half(rdlen);
      for (int i = 0; i < int'(rdlen); i++)
         frame_bytes.push_back(i < 4 ? addr[31 - 8 * i -: 8] : 8'($urandom));
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic first);
      int gap;
      if ($urandom_range(0, 31) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, MaxGap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= first;
      do @(posedge clock); while (req_tready !== 1'b1);
      parse_byte(b, first);
   endtask

   task automatic send_frame_part(input int from_idx, input int to_idx);
      for (int i = from_idx; i <= to_idx; i++) begin
         send_byte(frame_bytes[i], i == 0);
         frame_bytes_sent++;
      end
   endtask

   task automatic send_frame();
      send_frame_part(0, frame_bytes.size() - 1);
      frame_bytes.delete();
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (parsed_results.size() != 0);
   endtask

   task automatic set_question_length(input logic [7:0] len);
      wait_results_drained();
      repeat (SettleCycles) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= len;
      @(posedge clock);
      csr_we <= 1'b0;
      question_length = len;
   endtask

   task automatic test_idle_and_errors();
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      put_header(16'hFFFF, 16'h8183, 16'd1, 16'd2, 16'd0, 16'd0, RrTypeA, RrClassIn,
                 question_length);
      send_frame();
      send_byte(8'hA5, 1'b0);
      put_header(16'h0000, FlagsAnswer, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'h0000, question_length);
      send_frame();
      put_header(16'h8001, 16'h7FFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, RrTypeA, RrClassIn,
                 question_length);
      send_frame();
   endtask

   task automatic test_answer_records();
      put_header(16'h1234, FlagsAnswer, 16'd1, 16'd5, 16'd0, 16'd0, RrTypeA, RrClassIn,
                 question_length);
      put_record(RrTypeA, RrClassIn, Ipv4Length, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      put_record(RrTypeCname, RrClassIn, 16'd0, 32'd300, 32'd0);
      put_record(RrTypeAaaa, RrClassIn, Ipv4Length, 32'd60, 32'h0A00_0001);
      put_record(RrTypeA, RrClassChaos, Ipv4Length, 32'd60, 32'h0A00_0002);
      put_record(RrTypeA, RrClassIn, Ipv4Length, 32'd0, 32'd0);
      send_frame();
      put_header(16'h4321, FlagsAnswer, 16'd1, 16'd2, 16'd1, 16'd1, RrTypeA, RrClassIn,
                 question_length);
      put_record(RrTypeA, RrClassIn, Ipv4Length, 32'd3600, 32'hC0A8_0001);
      put_record(RrTypeTxt, RrClassIn, 16'd3, 32'd10, 32'h1122_3344);
      send_frame();
      put_header(16'h0F0F, FlagsAnswer, 16'd1, 16'd1, 16'd0, 16'd0, RrTypeA, RrClassIn,
                 question_length);
      put_record(RrTypeCname, RrClassIn, 16'd0, 32'd5, 32'd0);
      send_frame();
      put_header(16'hF0F0, FlagsAnswer, 16'd1, 16'd1, 16'd0, 16'd0, RrTypeA, RrClassIn,
                 question_length);
      put_record(RrTypeA, RrClassIn, 16'd5, 32'h8000_0000, 32'h7F00_0001);
      send_frame();
   endtask

   task automatic test_restart();
      put_header(16'hAAAA, FlagsAnswer, 16'd1, 16'd1, 16'd0, 16'd0, RrTypeA, RrClassIn,
                 question_length);
      send_frame_part(0, 6);
      frame_bytes.delete();
      put_header(16'h5555, FlagsAnswer, 16'd1, 16'd2, 16'd0, 16'd0, RrTypeA, RrClassIn,
                 question_length);
      put_record(RrTypeA, RrClassIn, Ipv4Length, 32'd77, 32'h0808_0808);
      put_record(RrTypeA, RrClassIn, Ipv4Length, 32'd78, 32'h0808_0404);
      send_frame_part(0, frame_bytes.size() - 8);
      frame_bytes.delete();
      put_header(16'h6666, FlagsAnswer, 16'd1, 16'd1, 16'd0, 16'd0, RrTypeA, RrClassIn,
                 question_length);
      put_record(RrTypeA, RrClassIn, Ipv4Length, 32'd79, 32'h0101_0101);
      send_frame();
   endtask

   task automatic test_question_length();
      int tail;
      set_question_length(8'd255);
      put_header(16'h0255, FlagsAnswer, 16'd1, 16'd1, 16'd0, 16'd0, RrTypeA, RrClassIn, 255);
      put_record(RrTypeA, RrClassIn, Ipv4Length, 32'd1, 32'h0102_0304);
      send_frame();
      set_question_length(8'd1);
      put_header(16'h0001, FlagsAnswer, 16'd1, 16'd1, 16'd0, 16'd0, RrTypeA, RrClassIn, 1);
      put_record(RrTypeA, RrClassIn, Ipv4Length, 32'd2, 32'h0506_0708);
      send_frame();

      // The length is taken when the header completes, so a later write waits for the
      // next message.
      set_question_length(8'd2);
      put_header(16'h0202, FlagsAnswer, 16'd1, 16'd1, 16'd0, 16'd0, RrTypeA, RrClassIn, 2);
      put_record(RrTypeA, RrClassIn, Ipv4Length, 32'd3, 32'h090A_0B0C);
      tail = frame_bytes.size() - 1;
      send_frame_part(0, 12);
      set_question_length(8'd7);
      send_frame_part(13, tail);
      frame_bytes.delete();
      put_header(16'h0707, FlagsAnswer, 16'd1, 16'd1, 16'd0, 16'd0, RrTypeA, RrClassIn, 7);
      put_record(RrTypeA, RrClassIn, Ipv4Length, 32'd4, 32'h0D0E_0F10);
      send_frame();

      put_header(16'h0700, FlagsAnswer, 16'd1, 16'd1, 16'd0, 16'd0, RrTypeA, RrClassIn, 0);
      put_record(RrTypeA, RrClassIn, Ipv4Length, 32'd5, 32'h1112_1314);
      tail = frame_bytes.size() - 1;
      send_frame_part(0, 4);
      set_question_length(8'd0);
      send_frame_part(5, tail);
      frame_bytes.delete();
   endtask

   task automatic test_random_traffic();
      int          first_count;
      int          nrec;
      int          cut;
      logic [15:0] flags;
      logic [15:0] an;
      logic [15:0] qtype;
      logic [15:0] qclass;
      first_count = frame_bytes_sent;
      while (frame_bytes_sent - first_count < RandomBytes) begin
         if ($urandom_range(0, 7) == 0) begin
            if ($urandom_range(0, 19) == 0) set_question_length(8'($urandom_range(0, 255)));
            else set_question_length(8'($urandom_range(0, 8)));
         end
         flags = 16'($urandom);
         if ($urandom_range(0, 3) != 0) flags[3:0] = '0;
         nrec = $urandom_range(0, 4);
         an = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'(nrec);
         qtype = $urandom_range(0, 1) ? RrTypeA : 16'($urandom);
         qclass = $urandom_range(0, 1) ? RrClassIn : 16'($urandom);
         put_header(16'($urandom), flags, 16'($urandom), an, 16'($urandom), 16'($urandom),
                    qtype, qclass, question_length);
         repeat (nrec) begin
            case ($urandom_range(0, 9))
               0: put_record(16'($urandom), 16'($urandom), 16'($urandom_range(0, 8)),
                             $urandom, $urandom);
               1: put_record(RrTypeCname, RrClassIn, 16'($urandom_range(0, 300)),
                             $urandom, $urandom);
               2: put_record(RrTypeA, RrClassIn, 16'($urandom_range(0, 6)),
                             $urandom, $urandom);
               default: put_record(RrTypeA, RrClassIn, Ipv4Length, $urandom, $urandom);
            endcase
         end
         if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, frame_bytes.size() - 1);
            send_frame_part(0, cut - 1);
            frame_bytes.delete();
         end else begin
            send_frame();
         end
         if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
         if ($urandom_range(0, 9) == 0) wait_results_drained();
      end
   endtask

   initial begin : result_checker
      rsp_item_type got;
      rsp_item_type want;
      int           stall;
      wait (reset === 1'b0);
      forever begin
         if ($urandom_range(0, 31) == 0) rsp_burst = !rsp_burst;
         stall = rsp_burst ? 0 : $urandom_range(0, MaxGap);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         got = rsp_item_type'({rsp_tuser, rsp_tdata});
         if (parsed_results.size() == 0) begin
            note_failure($sformatf("unexpected result of kind %0d", got.kind));
         end else begin
            want = parsed_results.pop_front();
            check_field("result_kind", 32'(want.kind), 32'(got.kind));
            check_field("ipv4_address", want.ipv4_address, got.ipv4_address);
            check_field("time_to_live", want.time_to_live, got.time_to_live);
            check_field("record_number", 32'(want.record_number), 32'(got.record_number));
            check_field("message_id", 32'(want.message_id), 32'(got.message_id));
            check_field("header_flags", 32'(want.header_flags), 32'(got.header_flags));
            check_field("question_count", 32'(want.question_count), 32'(got.question_count));
            check_field("answer_count", 32'(want.answer_count), 32'(got.answer_count));
            check_field("authority_count", 32'(want.authority_count),
                        32'(got.authority_count));
            check_field("additional_count", 32'(want.additional_count),
                        32'(got.additional_count));
            check_field("query_type", 32'(want.query_type), 32'(got.query_type));
            check_field("query_class", 32'(want.query_class), 32'(got.query_class));
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_and_errors();
      test_answer_records();
      test_restart();
      test_question_length();
      test_random_traffic();
      wait_results_drained();
      repeat (20) @(posedge clock);
      if (failures == 0 && parsed_results.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
